// ----- rtl/ftoa_pkg.sv -----
// shared types, constants and helpers for the temperature text formatter
package ftoa_pkg;

	// ascii codes used in the text
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_POINT = 8'h2e;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// text shown for a failed read
	localparam int         ERR_LEN  = 6;
	localparam logic [47:0] ERR_TEXT = "error!";

	// decimal weights removed by the shared subtract unit
	localparam logic [6:0] WEIGHT_HUNDREDS = 7'd100;
	localparam logic [6:0] WEIGHT_TENS     = 7'd10;

	// room for the text before padding; the longest is sign, three digits, point, fraction digit
	localparam int CORE_LEN = 8;

	typedef logic [7:0] char_t;

	// fraction digit: floor(frac * 10 / 16)
	function automatic logic [3:0] frac_digit(input logic [3:0] frac);
		logic [7:0] times_ten;
		times_ten = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
		return times_ten[7:4];
	endfunction

	// ascii code of a decimal digit
	function automatic char_t digit_char(input logic [3:0] digit);
		return CHAR_ZERO + {4'h0, digit};
	endfunction

endpackage

// ----- rtl/fixed_point_temp_to_ascii.sv -----
// top level: signed 1/16 degree reading to padded decimal ascii text
// digits come from repeated subtraction of 100 and 10 through one shared
// subtract unit, and a failed read skips this to load the error text
// new readings are held off (in_stall) until the last character has gone out;
// text is emitted one character per cycle unless the output stalls
// reset: arst_n clears the sequencer and output valid; the block is then idle
module fixed_point_temp_to_ascii
	import ftoa_pkg::*;
#(
	parameter int TEXT_WIDTH = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              read_ok,
	input  logic signed [11:0] raw_temp,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        text_char,
	output logic              last_char
);

	localparam int CNT_W = $clog2(TEXT_WIDTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]       state_q;
	logic             ok_q;
	logic             neg_q;
	logic [7:0]       rem_q;
	logic             hund_q;
	logic [3:0]       tens_q;
	logic [3:0]       frac_q;
	logic             dsel_q;
	logic [CNT_W-1:0] cnt_q;
	char_t            txt_q [TEXT_WIDTH];

	logic             in_beat;
	logic             out_beat;
	logic [11:0]      mag;
	logic             fits;
	logic [7:0]       difference;
	char_t            core [CORE_LEN];
	logic [2:0]       core_len;
	char_t            txt_next [TEXT_WIDTH];

	assign in_beat  = in_valid & ~in_stall;
	assign out_beat = out_valid & ~out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// magnitude of the reading, -2048 maps to 2048
	assign mag = raw_temp[11] ? (12'd0 - 12'(raw_temp)) : 12'(raw_temp);

	// shared unit: hundreds weight first, then tens
	ftoa_sub_unit u_sub (
		.remainder  (rem_q),
		.weight     (dsel_q ? WEIGHT_TENS : WEIGHT_HUNDREDS),
		.fits       (fits),
		.difference (difference)
	);

	// assemble the unpadded text from the extracted digits
	always_comb begin
		core_len = 3'd0;
		for (int i = 0; i < CORE_LEN; i++) begin
			core[i] = CHAR_SPACE;
		end
		if (ok_q) begin
			if (neg_q) begin
				core[core_len] = CHAR_MINUS;
				core_len = core_len + 3'd1;
			end
			if (hund_q) begin
				core[core_len] = digit_char(4'd1);
				core_len = core_len + 3'd1;
			end
			if (hund_q || (tens_q != 4'd0)) begin
				core[core_len] = digit_char(tens_q);
				core_len = core_len + 3'd1;
			end
			core[core_len] = digit_char(rem_q[3:0]);
			core_len = core_len + 3'd1;
			core[core_len] = CHAR_POINT;
			core_len = core_len + 3'd1;
			core[core_len] = digit_char(frac_q);
			core_len = core_len + 3'd1;
		end else begin
			for (int k = 0; k < ERR_LEN; k++) begin
				core[k] = ERR_TEXT[8*(ERR_LEN-1-k) +: 8];
			end
			core_len = 3'(ERR_LEN);
		end
	end

	// pad with spaces to the full text width
	always_comb begin
		for (int p = 0; p < TEXT_WIDTH; p++) begin
			txt_next[p] = CHAR_SPACE;
			if ((p < CORE_LEN) && (p < int'(core_len))) begin
				txt_next[p] = core[3'(p)];
			end
		end
	end

	// sequencer: capture, extract digits, load text, emit characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= read_ok ? ST_CONV : ST_LOAD;
					end
				end
				ST_CONV: begin
					if (!fits && dsel_q) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_EMIT;
					cnt_q   <= CNT_W'(TEXT_WIDTH);
				end
				ST_EMIT: begin
					if (out_beat) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers for digits and the text shifter
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					ok_q   <= read_ok;
					neg_q  <= raw_temp[11];
					rem_q  <= mag[11:4];
					frac_q <= frac_digit(mag[3:0]);
					hund_q <= 1'b0;
					tens_q <= 4'd0;
					dsel_q <= 1'b0;
				end
			end
			ST_CONV: begin
				if (fits) begin
					rem_q <= difference;
					if (dsel_q) begin
						tens_q <= tens_q + 4'd1;
					end else begin
						hund_q <= 1'b1;
					end
				end else begin
					dsel_q <= 1'b1;
				end
			end
			ST_LOAD: begin
				txt_q <= txt_next;
			end
			ST_EMIT: begin
				if (out_beat) begin
					for (int i = 0; i < TEXT_WIDTH - 1; i++) begin
						txt_q[i] <= txt_q[i+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output beat comes straight from the head of the shifter
	assign out_valid = (state_q == ST_EMIT);
	assign text_char = txt_q[0];
	assign last_char = (cnt_q == CNT_W'(1));

endmodule

// ----- rtl/ftoa_sub_unit.sv -----
// shared compare and subtract unit for digit extraction
module ftoa_sub_unit
	import ftoa_pkg::*;
(
	input  logic [7:0] remainder,
	input  logic [6:0] weight,
	output logic       fits,
	output logic [7:0] difference
);

	logic [8:0] diff_wide;

	// one subtraction, the borrow tells whether the weight fits
	assign diff_wide  = {1'b0, remainder} - {2'b00, weight};
	assign fits       = ~diff_wide[8];
	assign difference = diff_wide[7:0];

endmodule
